// ===== hdl/mau_pkg.sv =====
package mau_pkg;

    // operand and operation widths fixed by the interface
    localparam int OP_W   = 3;
    localparam int OPND_W = 32;

    // one step per operand bit, one pass per exponent bit
    localparam int               STEP_W    = 5;
    localparam logic [STEP_W-1:0] STEP_LAST = 5'd31;

    localparam logic [OPND_W-1:0] MOD_RESET = 32'd1000000007;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_POW = 3'd3;
    localparam logic [OP_W-1:0] OP_INV = 3'd4;
    localparam logic [OP_W-1:0] OP_DIV = 3'd5;

    // source and destination of one shared modular multiply
    typedef logic [2:0] t_mul_sel;
    localparam t_mul_sel MS_RED_A   = 3'd0;
    localparam t_mul_sel MS_RED_B   = 3'd1;
    localparam t_mul_sel MS_MUL_AB  = 3'd2;
    localparam t_mul_sel MS_POW_ACC = 3'd3;
    localparam t_mul_sel MS_POW_SQ  = 3'd4;
    localparam t_mul_sel MS_DIV_FIN = 3'd5;

    // direct updates of the result register
    typedef logic [2:0] t_res_sel;
    localparam t_res_sel RES_HOLD = 3'd0;
    localparam t_res_sel RES_ZERO = 3'd1;
    localparam t_res_sel RES_ADD  = 3'd2;
    localparam t_res_sel RES_SUB  = 3'd3;
    localparam t_res_sel RES_PACC = 3'd4;

    typedef struct packed {
        logic     load_in;
        logic     mul_start;
        t_mul_sel mul_sel;
        t_res_sel res_sel;
        logic     pow_init;
        logic     pow_base_b;
        logic     pow_exp_mod;
        logic     exp_shift;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic mul_wb;
        logic base_zero;
        logic exp_bit0;
        logic mod_small;
        logic out_free;
    } t_sts;

endpackage

// ===== hdl/mau_mulmod.sv =====
// Interleaved modular multiply: x * y mod m, one bit of y per cycle, MSB first.
// With x = 1 it reduces y mod m.
module mau_mulmod #(
    parameter int MB = 31
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [MB-1:0]                i_x,
    input  logic [mau_pkg::OPND_W-1:0]   i_y,
    input  logic [MB-1:0]                i_mod,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [MB-1:0]                o_acc
);

    localparam int W = MB + 2;

    logic                          r_busy;
    logic                          r_done;
    logic [mau_pkg::STEP_W-1:0]    r_cnt;
    logic [MB-1:0]                 r_acc;
    logic [MB-1:0]                 r_x;
    logic [mau_pkg::OPND_W-1:0]    r_y;

    logic [W-1:0]  sum;
    logic [W-1:0]  m1;
    logic [W-1:0]  m2;
    logic [MB-1:0] n_acc;

    // sum < 3m, so at most two subtractions of m
    always_comb begin
        m1  = W'(i_mod);
        m2  = m1 << 1;
        sum = (W'(r_acc) << 1) + (r_y[mau_pkg::OPND_W-1] ? W'(r_x) : '0);
        if (sum >= m2) begin
            n_acc = MB'(sum - m2);
        end else if (sum >= m1) begin
            n_acc = MB'(sum - m1);
        end else begin
            n_acc = MB'(sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == mau_pkg::STEP_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_x   <= i_x;
            r_y   <= i_y;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_y   <= r_y << 1;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_acc  = r_acc;

`ifndef SYNTHESIS
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy && $past(r_cnt) == mau_pkg::STEP_LAST)
        else $error("mulmod done without a full pass");
`endif

endmodule

// ===== hdl/mau_dp.sv =====
module mau_dp #(
    parameter int MB = 31
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [MB-1:0]                i_cfg_modulus,
    input  logic [mau_pkg::OPND_W-1:0]   i_operand_a,
    input  logic [mau_pkg::OPND_W-1:0]   i_operand_b,
    input  mau_pkg::t_cmd                i_cmd,
    output mau_pkg::t_sts                o_sts,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [MB-1:0]                o_result
);

    localparam logic [MB-1:0] MOD_INIT = MB'(mau_pkg::MOD_RESET);

    logic [MB-1:0]               r_mod;
    logic [mau_pkg::OPND_W-1:0]  r_ra;
    logic [mau_pkg::OPND_W-1:0]  r_rb;
    logic [mau_pkg::OPND_W-1:0]  r_exp;
    logic [MB-1:0]               r_base;
    logic [MB-1:0]               r_pacc;
    logic [MB-1:0]               r_res;
    logic [MB-1:0]               r_out;
    logic                        r_out_vld;
    mau_pkg::t_mul_sel           r_dst;
    logic                        r_wb;

    logic [MB-1:0]               mul_x;
    logic [mau_pkg::OPND_W-1:0]  mul_y;
    logic                        mul_busy;
    logic                        mul_done;
    logic [MB-1:0]               mul_acc;
    logic [MB:0]                 add_sum;
    logic [MB:0]                 sub_dif;
    logic [MB-1:0]               add_r;
    logic [MB-1:0]               sub_r;

    always_comb begin
        unique case (i_cmd.mul_sel)
            mau_pkg::MS_RED_A: begin
                mul_x = MB'(1);
                mul_y = r_ra;
            end
            mau_pkg::MS_RED_B: begin
                mul_x = MB'(1);
                mul_y = r_rb;
            end
            mau_pkg::MS_MUL_AB: begin
                mul_x = r_ra[MB-1:0];
                mul_y = r_rb;
            end
            mau_pkg::MS_POW_ACC: begin
                mul_x = r_base;
                mul_y = mau_pkg::OPND_W'(r_pacc);
            end
            mau_pkg::MS_POW_SQ: begin
                mul_x = r_base;
                mul_y = mau_pkg::OPND_W'(r_base);
            end
            mau_pkg::MS_DIV_FIN: begin
                mul_x = r_ra[MB-1:0];
                mul_y = mau_pkg::OPND_W'(r_pacc);
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    mau_mulmod #(.MB(MB)) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_x     (mul_x),
        .i_y     (mul_y),
        .i_mod   (r_mod),
        .o_busy  (mul_busy),
        .o_done  (mul_done),
        .o_acc   (mul_acc)
    );

    // both operands already reduced below m
    always_comb begin
        add_sum = (MB+1)'(r_ra[MB-1:0]) + (MB+1)'(r_rb[MB-1:0]);
        sub_dif = (MB+1)'(r_ra[MB-1:0]) - (MB+1)'(r_rb[MB-1:0]);
        add_r   = (add_sum >= (MB+1)'(r_mod)) ? MB'(add_sum - (MB+1)'(r_mod)) : MB'(add_sum);
        sub_r   = sub_dif[MB] ? MB'(sub_dif + (MB+1)'(r_mod)) : MB'(sub_dif);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod     <= MOD_INIT;
            r_out_vld <= 1'b0;
            r_wb      <= 1'b0;
        end else begin
            r_wb <= mul_done;
            if (i_cfg_valid) begin
                r_mod <= i_cfg_modulus;
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_dst <= i_cmd.mul_sel;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
        if (i_cmd.load_in) begin
            r_ra  <= i_operand_a;
            r_rb  <= i_operand_b;
            r_exp <= i_operand_b;
        end else if (i_cmd.pow_init) begin
            r_base <= i_cmd.pow_base_b ? r_rb[MB-1:0] : r_ra[MB-1:0];
            r_pacc <= MB'(1);
            if (i_cmd.pow_exp_mod) begin
                r_exp <= mau_pkg::OPND_W'(r_mod) - mau_pkg::OPND_W'(2);
            end
        end else if (i_cmd.exp_shift) begin
            r_exp <= r_exp >> 1;
        end else if (mul_done) begin
            unique case (r_dst)
                mau_pkg::MS_RED_A:   r_ra   <= mau_pkg::OPND_W'(mul_acc);
                mau_pkg::MS_RED_B:   r_rb   <= mau_pkg::OPND_W'(mul_acc);
                mau_pkg::MS_POW_ACC: r_pacc <= mul_acc;
                mau_pkg::MS_POW_SQ:  r_base <= mul_acc;
                default:             r_res  <= mul_acc;
            endcase
        end
        unique case (i_cmd.res_sel)
            mau_pkg::RES_ZERO: r_res <= '0;
            mau_pkg::RES_ADD:  r_res <= add_r;
            mau_pkg::RES_SUB:  r_res <= sub_r;
            mau_pkg::RES_PACC: r_res <= r_pacc;
            default: ;
        endcase
    end

    always_comb begin
        o_sts.mul_wb    = r_wb;
        o_sts.base_zero = (r_base == '0);
        o_sts.exp_bit0  = r_exp[0];
        o_sts.mod_small = (r_mod < MB'(2));
        o_sts.out_free  = !r_out_vld || i_out_ready;
    end

    assign o_out_valid = r_out_vld;
    assign o_result    = r_out;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mul_start |-> !mul_busy && !mul_done)
        else $error("multiply started while the unit is in use");
    a_res_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (r_mod < MB'(2)) || (r_res < r_mod))
        else $error("result not reduced below the modulus");
`endif

endmodule

// ===== hdl/mau_ctrl.sv =====
module mau_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [mau_pkg::OP_W-1:0]    i_operation,
    input  mau_pkg::t_sts               i_sts,
    output mau_pkg::t_cmd               o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_RA    = 4'd2;
    localparam logic [3:0] S_RB    = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_PZ    = 4'd5;
    localparam logic [3:0] S_PBIT  = 4'd6;
    localparam logic [3:0] S_PACC  = 4'd7;
    localparam logic [3:0] S_PSQ   = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0]                   r_state;
    logic [3:0]                   n_state;
    logic [mau_pkg::OP_W-1:0]     r_op;
    logic [mau_pkg::OP_W-1:0]     n_op;
    logic [mau_pkg::STEP_W-1:0]   r_pit;
    logic [mau_pkg::STEP_W-1:0]   n_pit;
    logic                         last_bit;

    assign last_bit = (r_pit == mau_pkg::STEP_LAST);

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_pit   = r_pit;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_op          = i_operation;
                    if (i_sts.mod_small || i_operation > mau_pkg::OP_DIV) begin
                        o_cmd.res_sel = mau_pkg::RES_ZERO;
                        n_state       = S_FIN;
                    end else begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = mau_pkg::MS_RED_A;
                n_state         = S_RA;
            end
            S_RA: begin
                if (i_sts.mul_wb) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = mau_pkg::MS_RED_B;
                    n_state         = S_RB;
                end
            end
            S_RB: begin
                if (i_sts.mul_wb) begin
                    priority if (r_op == mau_pkg::OP_ADD) begin
                        o_cmd.res_sel = mau_pkg::RES_ADD;
                        n_state       = S_FIN;
                    end else if (r_op == mau_pkg::OP_SUB) begin
                        o_cmd.res_sel = mau_pkg::RES_SUB;
                        n_state       = S_FIN;
                    end else if (r_op == mau_pkg::OP_MUL) begin
                        o_cmd.mul_start = 1'b1;
                        o_cmd.mul_sel   = mau_pkg::MS_MUL_AB;
                        n_state         = S_MUL;
                    end else begin
                        o_cmd.pow_init    = 1'b1;
                        o_cmd.pow_base_b  = (r_op == mau_pkg::OP_DIV);
                        o_cmd.pow_exp_mod = (r_op != mau_pkg::OP_POW);
                        n_pit             = '0;
                        n_state           = S_PZ;
                    end
                end
            end
            S_MUL: begin
                if (i_sts.mul_wb) begin
                    n_state = S_FIN;
                end
            end
            S_PZ: begin
                // zero base gives zero, whatever the exponent
                if (i_sts.base_zero) begin
                    o_cmd.res_sel = mau_pkg::RES_ZERO;
                    n_state       = S_FIN;
                end else begin
                    n_state = S_PBIT;
                end
            end
            S_PBIT: begin
                if (i_sts.exp_bit0) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = mau_pkg::MS_POW_ACC;
                    n_state         = S_PACC;
                end else if (last_bit) begin
                    if (r_op == mau_pkg::OP_DIV) begin
                        o_cmd.mul_start = 1'b1;
                        o_cmd.mul_sel   = mau_pkg::MS_DIV_FIN;
                        n_state         = S_MUL;
                    end else begin
                        o_cmd.res_sel = mau_pkg::RES_PACC;
                        n_state       = S_FIN;
                    end
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = mau_pkg::MS_POW_SQ;
                    n_state         = S_PSQ;
                end
            end
            S_PACC: begin
                if (i_sts.mul_wb) begin
                    if (!last_bit) begin
                        o_cmd.mul_start = 1'b1;
                        o_cmd.mul_sel   = mau_pkg::MS_POW_SQ;
                        n_state         = S_PSQ;
                    end else if (r_op == mau_pkg::OP_DIV) begin
                        o_cmd.mul_start = 1'b1;
                        o_cmd.mul_sel   = mau_pkg::MS_DIV_FIN;
                        n_state         = S_MUL;
                    end else begin
                        o_cmd.res_sel = mau_pkg::RES_PACC;
                        n_state       = S_FIN;
                    end
                end
            end
            S_PSQ: begin
                if (i_sts.mul_wb) begin
                    o_cmd.exp_shift = 1'b1;
                    n_pit           = r_pit + 1'b1;
                    n_state         = S_PBIT;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pit   <= '0;
        end else begin
            r_state <= n_state;
            r_pit   <= n_pit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
    end

    assign o_ready = (r_state == S_IDLE);

`ifndef SYNTHESIS
    a_pit_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exp_shift |=> r_pit == $past(r_pit) + 1'b1 && r_state == S_PBIT)
        else $error("exponent bit count out of step with the shift");
`endif

endmodule

// ===== hdl/modular_arithmetic_unit_core.sv =====
// Channel   Direction  Handshake                  Payload
// input     in         i_valid / o_ready          i_operation, i_operand_a, i_operand_b
// result    out        o_valid / i_ready          o_result
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_modulus
//
// One item at a time. Both operands are first reduced mod m on the shared bit-serial multiply
// unit, one step per operand bit. Add and subtract then need no further multiply, multiply
// needs one; power and inverse run up to 32 multiplies and 31 squarings, divide one multiply
// more. A modulus below 2 or an unused code gives 0. Reset is synchronous, active low;
// modulus resets to 1000000007. A finished result waits in the output register while the
// next item is taken.
module modular_arithmetic_unit_core #(
    parameter int MODULUS_BITS = 31
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // item input
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [mau_pkg::OP_W-1:0]     i_operation,
    input  logic [mau_pkg::OPND_W-1:0]   i_operand_a,
    input  logic [mau_pkg::OPND_W-1:0]   i_operand_b,
    // result output
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [MODULUS_BITS-1:0]      o_result,
    // modulus register write
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [MODULUS_BITS-1:0]      i_cfg_modulus
);

    mau_pkg::t_cmd cmd;
    mau_pkg::t_sts sts;

    // the modulus register takes every transfer at once
    assign o_cfg_ready = 1'b1;

    // sequencer: operand reduction, operation dispatch, square-and-multiply loop
    mau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // operand registers, shared modular multiplier, result and output registers
    mau_dp #(.MB(MODULUS_BITS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_modulus (i_cfg_modulus),
        .i_operand_a   (i_operand_a),
        .i_operand_b   (i_operand_b),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_ready   (i_ready),
        .o_out_valid   (o_valid),
        .o_result      (o_result)
    );

endmodule
